[rtl/sscd_pkg.sv]
`timescale 1ns / 1ps
// sscd_pkg: shared types, constants and helpers of the swept sphere contact time block
// depends on nothing; imported by every module of the block

package sscd_pkg;

   localparam int FRAC_BITS = 16;

   // gap value: floor root (32 bit) minus radius sum (32 bit)
   localparam int GAP_W = 34;
   // width used for gap differences and their differences
   localparam int CMP_W = 37;
   // width of divisor, bounded by twice the largest gap
   localparam int DEN_W = 34;

   localparam int SQ_STEPS     = 32;
   localparam int SQ_PER_STAGE = 2;
   localparam int SQ_STAGES    = SQ_STEPS / SQ_PER_STAGE;
   // product, saturate, square, sum, root stages, subtract
   localparam int GAP_LAT      = SQ_STAGES + 5;

   localparam int DIV_BITS      = 32;
   localparam int DIV_PER_STAGE = 2;
   localparam int DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;

   localparam int PAY_DEPTH  = GAP_LAT + DIV_STAGES + 2;
   localparam int PIPE_DEPTH = 2 * GAP_LAT + DIV_STAGES + 2;

   localparam logic [31:0] NEVER_TIME = 32'h7FFF_FFFF;

   localparam logic [1:0] ST_OVERLAP = 2'd0;
   localparam logic [1:0] ST_CONTACT = 2'd1;
   localparam logic [1:0] ST_NONE    = 2'd2;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_TIME = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EQUAL_TOL  = 1'b1;

   localparam logic [30:0] FRAME_RESET = 31'd1092;
   localparam logic [15:0] TOL_RESET   = 16'd1;

   typedef enum logic [1:0] {
      MODE_DONE   = 2'd0,
      MODE_LINEAR = 2'd1,
      MODE_VEE    = 2'd2
   } mode_type;

   typedef struct packed {
      logic signed [31:0] rel_pos_x;
      logic signed [31:0] rel_pos_y;
      logic signed [31:0] rel_pos_z;
      logic signed [31:0] rel_vel_x;
      logic signed [31:0] rel_vel_y;
      logic signed [31:0] rel_vel_z;
      logic [30:0]        radius_first;
      logic [30:0]        radius_second;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] contact_time;
      logic [1:0]         contact_status;
   } rsp_word_type;

   // result candidate that travels beside the divider and the check gap unit
   typedef struct packed {
      mode_type    mode;
      logic [31:0] ctime;
      logic [1:0]  status;
   } side_type;

   function automatic logic near_eq(input logic signed [CMP_W-1:0] a,
                                    input logic signed [CMP_W-1:0] b,
                                    input logic [15:0] tol);
      logic signed [CMP_W-1:0] d;
      logic [CMP_W-1:0] m;
      d = a - b;
      m = d[CMP_W-1] ? CMP_W'(-d) : CMP_W'(d);
      return m <= CMP_W'(tol);
   endfunction

endpackage

[rtl/sscd_isqrt.sv]
`timescale 1ns / 1ps
// sscd_isqrt: pipelined floor square root of a 64-bit value, two result bits per stage
// depends on sscd_pkg

module sscd_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] radicand,
   output logic [31:0] root
);
   import sscd_pkg::*;

   logic [63:0] x_ff   [SQ_STAGES];
   logic [63:0] res_ff [SQ_STAGES];

   for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
      logic [63:0] x_src;
      logic [63:0] res_src;
      logic [63:0] x_in;
      logic [63:0] res_in;

      if (s == 0) begin : g_first
         assign x_src   = radicand;
         assign res_src = '0;
      end else begin : g_next
         assign x_src   = x_ff[s-1];
         assign res_src = res_ff[s-1];
      end

      always_comb begin
         logic [63:0] b;
         x_in   = x_src;
         res_in = res_src;
         for (int j = 0; j < SQ_PER_STAGE; j++) begin
            b = 64'd1 << (62 - 2 * (s * SQ_PER_STAGE + j));
            if (x_in >= res_in + b) begin
               x_in   = x_in - (res_in + b);
               res_in = (res_in >> 1) + b;
            end else begin
               res_in = res_in >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[s]   <= x_in;
            res_ff[s] <= res_in;
         end
      end
   end

   assign root = res_ff[SQ_STAGES-1][31:0];

endmodule

[rtl/sscd_gap.sv]
`timescale 1ns / 1ps
// sscd_gap: pipelined gap |pos + vel*t| - r1 - r2 at one sample time
// depends on sscd_pkg and sscd_isqrt

module sscd_gap (
   input  logic                                clock,
   input  logic                                en,
   input  sscd_pkg::req_word_type              pair,
   input  logic [31:0]                         sample_time,
   output logic signed [sscd_pkg::GAP_W-1:0]   gap
);
   import sscd_pkg::*;

   localparam logic signed [64:0] SAT_HI = 65'sh0_7FFF_FFFF;
   localparam logic signed [64:0] SAT_LO = -65'sh0_8000_0000;

   logic signed [31:0] pos [3];
   logic signed [31:0] vel [3];

   logic signed [64:0] prod_ff [3];
   logic signed [64:0] prod_in [3];
   logic signed [31:0] pos_ff  [3];
   logic [31:0]        rs1_ff;
   logic [31:0]        mag_ff  [3];
   logic [31:0]        mag_in  [3];
   logic [31:0]        rs2_ff;
   logic [63:0]        sq_ff   [3];
   logic [31:0]        rs3_ff;
   logic [63:0]        sum_ff;
   logic [31:0]        rs4_ff;
   logic [31:0]        rdl_ff  [SQ_STAGES];
   logic [31:0]        root;
   logic signed [GAP_W-1:0] gap_ff;

   always_comb begin
      pos[0] = pair.rel_pos_x;
      pos[1] = pair.rel_pos_y;
      pos[2] = pair.rel_pos_z;
      vel[0] = pair.rel_vel_x;
      vel[1] = pair.rel_vel_y;
      vel[2] = pair.rel_vel_z;
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = vel[i] * $signed({1'b0, sample_time});
      end
   end

   // floor shift, add, clamp to 32 bits, magnitude
   always_comb begin
      logic signed [64:0] wide;
      logic signed [31:0] c32;
      for (int i = 0; i < 3; i++) begin
         wide = 65'(pos_ff[i]) + (prod_ff[i] >>> FRAC_BITS);
         if (wide > SAT_HI) begin
            c32 = SAT_HI[31:0];
         end else if (wide < SAT_LO) begin
            c32 = SAT_LO[31:0];
         end else begin
            c32 = wide[31:0];
         end
         mag_in[i] = c32[31] ? 32'(-c32) : 32'(c32);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= prod_in[i];
            pos_ff[i]  <= pos[i];
            mag_ff[i]  <= mag_in[i];
            sq_ff[i]   <= 64'(mag_ff[i]) * 64'(mag_ff[i]);
         end
         rs1_ff <= 32'(pair.radius_first) + 32'(pair.radius_second);
         rs2_ff <= rs1_ff;
         rs3_ff <= rs2_ff;
         sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         rs4_ff <= rs3_ff;
         rdl_ff[0] <= rs4_ff;
         for (int k = 1; k < SQ_STAGES; k++) begin
            rdl_ff[k] <= rdl_ff[k-1];
         end
         gap_ff <= $signed({2'b00, root}) - $signed({2'b00, rdl_ff[SQ_STAGES-1]});
      end
   end

   sscd_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (sum_ff),
      .root     (root)
   );

   assign gap = gap_ff;

endmodule

[rtl/sscd_div.sv]
`timescale 1ns / 1ps
// sscd_div: pipelined restoring divider, 32-bit quotient, two quotient bits per stage
// depends on sscd_pkg; the caller keeps the upper dividend below the divisor

module sscd_div (
   input  logic                            clock,
   input  logic                            en,
   input  logic [62:0]                     dividend,
   input  logic [sscd_pkg::DEN_W-1:0]      divisor,
   output logic [31:0]                     quotient
);
   import sscd_pkg::*;

   logic [DEN_W-1:0] rem_ff [DIV_STAGES];
   logic [31:0]      acc_ff [DIV_STAGES];
   logic [DEN_W-1:0] den_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [DEN_W-1:0] rem_src;
      logic [31:0]      acc_src;
      logic [DEN_W-1:0] den_src;
      logic [DEN_W-1:0] rem_in;
      logic [31:0]      acc_in;

      if (s == 0) begin : g_first
         assign rem_src = DEN_W'(dividend[62:32]);
         assign acc_src = dividend[31:0];
         assign den_src = divisor;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign acc_src = acc_ff[s-1];
         assign den_src = den_ff[s-1];
      end

      always_comb begin
         logic [DEN_W:0] trial;
         rem_in = rem_src;
         acc_in = acc_src;
         for (int j = 0; j < DIV_PER_STAGE; j++) begin
            trial  = {rem_in, acc_in[31]};
            acc_in = {acc_in[30:0], 1'b0};
            if (trial >= {1'b0, den_src}) begin
               trial     = trial - {1'b0, den_src};
               acc_in[0] = 1'b1;
            end
            rem_in = trial[DEN_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            acc_ff[s] <= acc_in;
            den_ff[s] <= den_src;
         end
      end
   end

   assign quotient = acc_ff[DIV_STAGES-1];

endmodule

[rtl/swept_sphere_contact_time_top.sv]
`timescale 1ns / 1ps
// swept_sphere_contact_time_top: contact time of two moving spheres over one frame
// depends on sscd_pkg, sscd_gap and sscd_div
//
// usage
// - req channel: one sphere pair word (relative position, relative velocity, radii)
//   is taken at an edge with req_valid high and req_stall low
// - rsp channel: one word (contact_time, contact_status) per request, in order,
//   taken at an edge with rsp_valid high and rsp_stall low
// - csr channel: frame_time (index 0) and equal_tolerance (index 1), always ready;
//   write only while no request is in flight
// - throughput: one word per cycle while the pipeline is not frozen by a stall, set by
//   the fully pipelined gap units, divider and root stages
// - structure: three gap units sample t = 0, dt/2, dt in parallel (21 stages each),
//   two stages classify and form the dividend, a 16-stage divider gives the
//   candidate time, and a fourth gap unit checks the gap one lsb later
// - stall: while the response register holds a word and rsp_stall is high the
//   whole pipeline freezes and req_stall is raised; nothing is lost or repeated
// - reset: clears all valid bits and loads the csr reset values
//   (frame_time 1092, equal_tolerance 1)

module swept_sphere_contact_time_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  sscd_pkg::req_word_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output sscd_pkg::rsp_word_type                rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sscd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [31:0]                           csr_wdata
);
   import sscd_pkg::*;

   // configuration
   logic [30:0] frame_time_ff;
   logic [15:0] equal_tol_ff;
   logic [29:0] half_time;

   // pipeline control
   logic adv;
   logic vld_ff [PIPE_DEPTH];
   logic accept;

   // payload line feeding the check gap unit
   req_word_type pay_ff [PAY_DEPTH];

   // gap samples
   logic signed [GAP_W-1:0] g0, g1, g2, g3;

   // classification stage
   side_type         c1_side_in, c1_side_ff;
   logic [DEN_W-1:0] c1_den_in,  c1_den_ff;
   logic [30:0]      c1_mult_in, c1_mult_ff;
   logic [31:0]      c1_d0_ff;

   // product stage
   logic [62:0]      num_ff;
   side_type         c2_side_ff;
   logic [DEN_W-1:0] c2_den_ff;

   // beside the divider and the check gap unit
   side_type    div_side;
   side_type    sd_ff [DIV_STAGES];
   logic [31:0] quot;
   side_type    post_side;
   side_type    sv_ff [GAP_LAT];
   side_type    fin_side;

   rsp_word_type rsp_ff;
   logic         rsp_valid_ff;

   assign csr_ready = 1'b1;
   assign half_time = frame_time_ff[30:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_time_ff <= FRAME_RESET;
         equal_tol_ff  <= TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_TIME: frame_time_ff <= csr_wdata[30:0];
            CSR_EQUAL_TOL:  equal_tol_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // whole pipe moves unless a held response is stalled
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= accept;
         for (int k = 1; k < PIPE_DEPTH; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pay_ff[0] <= req_data;
         for (int k = 1; k < PAY_DEPTH; k++) begin
            pay_ff[k] <= pay_ff[k-1];
         end
      end
   end

   // gap at start, mid frame and end of frame
   sscd_gap u_gap0 (
      .clock       (clock),
      .en          (adv),
      .pair        (req_data),
      .sample_time (32'd0),
      .gap         (g0)
   );

   sscd_gap u_gap1 (
      .clock       (clock),
      .en          (adv),
      .pair        (req_data),
      .sample_time ({2'b00, half_time}),
      .gap         (g1)
   );

   sscd_gap u_gap2 (
      .clock       (clock),
      .en          (adv),
      .pair        (req_data),
      .sample_time ({1'b0, frame_time_ff}),
      .gap         (g2)
   );

   // classify the three samples
   always_comb begin
      logic signed [CMP_W-1:0] s0, s1, s2, e01, e12, dref, lin_den, vee_den;
      s0  = CMP_W'(g0);
      s1  = CMP_W'(g1);
      s2  = CMP_W'(g2);
      e01 = s0 - s1;
      e12 = s1 - s2;
      dref    = (s0 > s2) ? s0 : s2;
      lin_den = s0 - s2;
      vee_den = dref - s1;

      c1_side_in.mode   = MODE_DONE;
      c1_side_in.ctime  = NEVER_TIME;
      c1_side_in.status = ST_NONE;
      c1_den_in  = '0;
      c1_mult_in = '0;

      if (s0 <= 0) begin
         // already overlapping
         c1_side_in.ctime  = '0;
         c1_side_in.status = ST_OVERLAP;
      end else if (near_eq(s0, s1, equal_tol_ff) && near_eq(s0, s2, equal_tol_ff)) begin
         // parallel motion
      end else if (s0 < s1 && near_eq(e01, e12, equal_tol_ff)) begin
         // receding along a line
      end else if (s0 > s1 && near_eq(e01, e12, equal_tol_ff)) begin
         // approaching along a line, contact only if end gap closed
         if (s2 <= 0) begin
            c1_side_in.mode = MODE_LINEAR;
            c1_den_in  = lin_den[DEN_W-1:0];
            c1_mult_in = frame_time_ff;
         end
      end else begin
         // v-shaped curve, needs a descending side and a nonzero half frame
         if (vee_den > 0 && half_time != '0) begin
            c1_side_in.mode = MODE_VEE;
            c1_den_in  = vee_den[DEN_W-1:0];
            c1_mult_in = {1'b0, half_time};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_side_ff <= c1_side_in;
         c1_den_ff  <= c1_den_in;
         c1_mult_ff <= c1_mult_in;
         c1_d0_ff   <= g0[31:0];
         num_ff     <= 63'(c1_d0_ff) * 63'(c1_mult_ff);
         c2_side_ff <= c1_side_ff;
         c2_den_ff  <= c1_den_ff;
      end
   end

   // a v-shaped quotient at or above 2^32 is past any frame
   always_comb begin
      div_side = c2_side_ff;
      if (c2_side_ff.mode == MODE_VEE && DEN_W'(num_ff[62:32]) >= c2_den_ff) begin
         div_side.mode = MODE_DONE;
      end
   end

   sscd_div u_div (
      .clock    (clock),
      .en       (adv),
      .dividend (num_ff),
      .divisor  (c2_den_ff),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sd_ff[0] <= div_side;
         for (int k = 1; k < DIV_STAGES; k++) begin
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   // take the quotient as candidate time
   always_comb begin
      post_side = sd_ff[DIV_STAGES-1];
      case (sd_ff[DIV_STAGES-1].mode)
         MODE_LINEAR: begin
            post_side.mode   = MODE_DONE;
            post_side.ctime  = quot;
            post_side.status = ST_CONTACT;
         end
         MODE_VEE: begin
            if (quot <= {1'b0, frame_time_ff}) begin
               post_side.ctime = quot;
            end else begin
               post_side.mode = MODE_DONE;
            end
         end
         default: ;
      endcase
   end

   // confirming gap one lsb after the candidate
   sscd_gap u_gap3 (
      .clock       (clock),
      .en          (adv),
      .pair        (pay_ff[PAY_DEPTH-1]),
      .sample_time (quot + 32'd1),
      .gap         (g3)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sv_ff[0] <= post_side;
         for (int k = 1; k < GAP_LAT; k++) begin
            sv_ff[k] <= sv_ff[k-1];
         end
      end
   end

   always_comb begin
      fin_side = sv_ff[GAP_LAT-1];
      if (sv_ff[GAP_LAT-1].mode == MODE_VEE) begin
         if (g3[GAP_W-1]) begin
            fin_side.status = ST_CONTACT;
         end else begin
            fin_side.ctime  = NEVER_TIME;
            fin_side.status = ST_NONE;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.contact_time   <= fin_side.ctime;
         rsp_ff.contact_status <= fin_side.status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[dv/swept_sphere_contact_time_top_tb.sv]
`timescale 1ns / 1ps
// swept_sphere_contact_time_top_tb: self-checking bench for the swept sphere contact time block
// depends on sscd_pkg and swept_sphere_contact_time_top; predicts each response word in order

module swept_sphere_contact_time_top_tb;
   import sscd_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_word_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_word_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_wdata;

   swept_sphere_contact_time_top dut (.*);

   // predictor copy of the registers
   logic [30:0] frame_len;
   logic [15:0] tol;

   rsp_word_type contact_q[$];
   int errors;
   int send_idle_pct;
   int recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit, far above the slowest correct run
   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // floor shift of a signed product
   function automatic longint fshift(input longint v);
      return v >>> FRAC_BITS;
   endfunction

   function automatic longint root_floor(input longint unsigned x);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v >>= 2;
      while (bit_v != 0) begin
         if (x >= res + bit_v) begin
            x -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   // gap between surfaces at time t
   function automatic longint gap_at_time(input req_word_type w, input longint t);
      longint p[3], v[3], c, rsum;
      longint unsigned m, acc;
      p[0] = longint'(w.rel_pos_x); p[1] = longint'(w.rel_pos_y); p[2] = longint'(w.rel_pos_z);
      v[0] = longint'(w.rel_vel_x); v[1] = longint'(w.rel_vel_y); v[2] = longint'(w.rel_vel_z);
      rsum = longint'(w.radius_first) + longint'(w.radius_second);
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         c = p[i] + fshift(v[i] * t);
         if (c > 64'sd2147483647) c = 64'sd2147483647;
         if (c < -64'sd2147483648) c = -64'sd2147483648;
         m = (c < 0) ? -c : c;
         acc += m * m;
      end
      return longint'(root_floor(acc)) - rsum;
   endfunction

   function automatic bit within_tol(input longint a, input longint b);
      longint d;
      d = a - b;
      if (d < 0) d = -d;
      return d <= longint'(tol);
   endfunction

   function automatic rsp_word_type predict_contact(input req_word_type w);
      rsp_word_type r;
      longint d0, d1, d2, dref, den, dt, h;
      longint unsigned c;
      dt = longint'(frame_len);
      h = longint'(frame_len >> 1);
      r.contact_time = NEVER_TIME;
      r.contact_status = ST_NONE;
      d0 = gap_at_time(w, 0);
      if (d0 <= 0) begin
         r.contact_time = 0;
         r.contact_status = ST_OVERLAP;
      end else begin
         d1 = gap_at_time(w, h);
         d2 = gap_at_time(w, dt);
         if (within_tol(d0, d1) && within_tol(d0, d2)) begin
            // parallel
         end else if (d0 < d1 && within_tol(d0 - d1, d1 - d2)) begin
            // receding
         end else if (d0 > d1 && within_tol(d0 - d1, d1 - d2)) begin
            if (d2 <= 0) begin
               // all terms positive and the product stays below 2^63
               r.contact_time = 32'((d0 * dt) / (d0 - d2));
               r.contact_status = ST_CONTACT;
            end
         end else begin
            dref = (d0 > d2) ? d0 : d2;
            den = dref - d1;
            if (den > 0 && h != 0) begin
               c = (d0 * h) / den;
               if (c <= dt && gap_at_time(w, c + 1) < 0) begin
                  r.contact_time = 32'(c);
                  r.contact_status = ST_CONTACT;
               end
            end
         end
      end
      return r;
   endfunction

   // checker and receiver stall generator
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (contact_q.size() == 0) begin
               $display("%t unexpected word %h", $time, rsp_data);
               errors++;
            end else begin
               exp_w = contact_q.pop_front();
               if (rsp_data.contact_time !== exp_w.contact_time) begin
                  $display("%t contact_time expected %h actual %h", $time,
                           exp_w.contact_time, rsp_data.contact_time);
                  errors++;
               end
               if (rsp_data.contact_status !== exp_w.contact_status) begin
                  $display("%t contact_status expected %h actual %h", $time,
                           exp_w.contact_status, rsp_data.contact_status);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // one word into the block; valid held until taken, prediction at acceptance
   // valid drops only on an idle cycle or when the pipe is drained
   task automatic send_pair(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      contact_q = {contact_q, predict_contact(w)};
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (contact_q.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
   endtask

   // register writes only while the pipe is empty
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      drain_pipe();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_FRAME_TIME) frame_len = val[30:0];
      else tol = val[15:0];
   endtask

   function automatic logic [31:0] rand_coord(input int span);
      logic [31:0] v;
      case ($urandom_range(3))
         0: v = $urandom;
         default: v = $urandom_range(2 * span) - span;
      endcase
      return v;
   endfunction

   // pair mostly on a collision course, with random content
   function automatic req_word_type closing_pair();
      req_word_type w;
      int span;
      span = 1 << $urandom_range(10, 24);
      w.rel_pos_x = rand_coord(span);
      w.rel_pos_y = rand_coord(span);
      w.rel_pos_z = rand_coord(span);
      if ($urandom_range(3) == 0) begin
         w.rel_vel_x = $urandom;
         w.rel_vel_y = $urandom;
         w.rel_vel_z = $urandom;
      end else begin
         // velocity roughly opposite the position, scaled by a random factor
         w.rel_vel_x = -(w.rel_pos_x <<< $urandom_range(4)) + $signed($urandom_range(4095) - 2048);
         w.rel_vel_y = -(w.rel_pos_y <<< $urandom_range(4)) + $signed($urandom_range(4095) - 2048);
         w.rel_vel_z = -(w.rel_pos_z <<< $urandom_range(4)) + $signed($urandom_range(4095) - 2048);
      end
      if ($urandom_range(9) == 0) begin
         w.radius_first = 31'($urandom);
         w.radius_second = 31'($urandom);
      end else begin
         w.radius_first = 31'($urandom_range(span / 2));
         w.radius_second = 31'($urandom_range(span / 2));
      end
      return w;
   endfunction

   task automatic test_directed();
      req_word_type w;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      // overlapping at start, radii at their extremes
      w = '0; w.radius_first = '1; w.radius_second = '1;
      send_pair(w);
      w = '0; send_pair(w);
      // parallel: no relative motion
      w = '0; w.rel_pos_x = 32'sd1 <<< 20; send_pair(w);
      // receding linear
      w.rel_vel_x = 32'sd1 <<< 24; send_pair(w);
      // approaching linear, head-on
      w = '0; w.rel_pos_x = 32'sd100 <<< 16; w.rel_vel_x = -(32'sd1 <<< 27);
      w.radius_first = 31'd1 << 16; send_pair(w);
      // V-shaped: pass-by with offset
      w = '0; w.rel_pos_x = 32'sd10 <<< 16; w.rel_pos_y = 32'sd1 <<< 16;
      w.rel_vel_x = -(32'sd20 <<< 16) * 60; w.radius_first = 31'd3 << 16; send_pair(w);
      w.radius_first = 31'd1 << 14; send_pair(w);
      // position and velocity extremes, saturation of each component
      w = '0; w.rel_pos_x = 32'h7FFF_FFFF; w.rel_pos_y = 32'h8000_0000;
      w.rel_pos_z = 32'h7FFF_FFFF; w.rel_vel_x = 32'h7FFF_FFFF;
      w.rel_vel_y = 32'h8000_0000; w.rel_vel_z = 32'h8000_0000; send_pair(w);
      w.rel_vel_x = 32'h8000_0000; w.rel_vel_y = 32'h7FFF_FFFF; send_pair(w);
      w.radius_first = '1; w.radius_second = 31'h1; send_pair(w);
      w = '1; send_pair(w);
      repeat (10) send_pair(closing_pair());
   endtask

   // shortest frame with a half frame of zero, then the longest frame at both tolerance extremes
   task automatic test_frame_extremes();
      write_csr(CSR_FRAME_TIME, 32'd1);
      repeat (40) send_pair(closing_pair());
      write_csr(CSR_FRAME_TIME, 32'h7FFF_FFFF);
      write_csr(CSR_EQUAL_TOL, 32'hFFFF);
      repeat (40) send_pair(closing_pair());
      write_csr(CSR_EQUAL_TOL, 32'd0);
      repeat (40) send_pair(closing_pair());
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      write_csr(CSR_FRAME_TIME, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 1 << 20));
      write_csr(CSR_EQUAL_TOL, $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(8));
      repeat (n) send_pair(closing_pair());
   endtask

   initial begin
      errors = 0;
      frame_len = FRAME_RESET;
      tol = TOL_RESET;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_frame_extremes();
      test_random_phase(0, 0, 200);
      test_random_phase(74, 0, 150);
      test_random_phase(0, 74, 150);
      // sender waits for the pipe to empty before the next phase
      drain_pipe();
      test_random_phase(10, 10, 200);
      test_random_phase(0, 0, 50);

      drain_pipe();
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[files.f]
rtl/sscd_pkg.sv
rtl/sscd_isqrt.sv
rtl/sscd_gap.sv
rtl/sscd_div.sv
rtl/swept_sphere_contact_time_top.sv
dv/swept_sphere_contact_time_top_tb.sv
